// ----- src/lgs_pkg.sv -----
// Shared types and constants for the Life generation step block.
// No dependencies; every other file of the block imports this package.
package lgs_pkg;

  // Width of the row ports; each row carries this many cells at most.
  localparam int CELLS_W = 64;
  // Width of the grid_width register.
  localparam int GRID_W_W = 7;
  // Width of the configuration data bus, padded to whole bytes.
  localparam int CFG_DATA_W = 8;
  // Largest row the core is built for, used as the default of MAX_WIDTH.
  localparam int MAX_WIDTH_DEF = 64;

  // Neighbor counts of rule B3/S23.
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Flags carried with each result row.
  typedef struct packed {
    logic grid_done;
    logic run_end;
  } lgs_flags_t;

  // Results that one accepted row pushes into the output queue.
  typedef struct packed {
    logic       push_a;
    logic       push_b;
    lgs_flags_t flags_a;
  } lgs_push_t;

endpackage

// ----- src/lgs_lane.sv -----
// One cell lane: counts the eight neighbors of a cell and applies B3/S23.
// Depends on lgs_pkg for the rule constants.
module lgs_lane (
  input  logic [2:0] above,
  input  logic [2:0] here,
  input  logic [2:0] below,
  output logic       alive_nxt
);
  import lgs_pkg::*;

  logic [3:0] count;

  always_comb begin
    count = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
          + 4'(here[0]) + 4'(here[2])
          + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);
    alive_nxt = (count == BIRTH_COUNT) || (here[1] && (count == SURVIVE_COUNT));
  end

endmodule

// ----- src/lgs_row.sv -----
// A row of cell lanes plus the merge stage that gathers the lane outputs.
// Depends on lgs_pkg and lgs_lane.
module lgs_row #(
  parameter int MAX_WIDTH = lgs_pkg::MAX_WIDTH_DEF
) (
  input  logic [MAX_WIDTH-1:0] mask,
  input  logic [MAX_WIDTH-1:0] above,
  input  logic [MAX_WIDTH-1:0] here,
  input  logic [MAX_WIDTH-1:0] below,
  output logic [MAX_WIDTH-1:0] next_row
);
  import lgs_pkg::*;

  // Dead cells pad both edges so that every lane sees three columns.
  logic [MAX_WIDTH+1:0] above_pad;
  logic [MAX_WIDTH+1:0] here_pad;
  logic [MAX_WIDTH+1:0] below_pad;
  logic [MAX_WIDTH-1:0] lane_out;

  assign above_pad = {1'b0, above & mask, 1'b0};
  assign here_pad  = {1'b0, here & mask, 1'b0};
  assign below_pad = {1'b0, below & mask, 1'b0};

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_lane
    lgs_lane u_lane (
      .above     (above_pad[k+2:k]),
      .here      (here_pad[k+2:k]),
      .below     (below_pad[k+2:k]),
      .alive_nxt (lane_out[k])
    );
  end

  // Merge: cells outside the configured width always read as dead.
  assign next_row = lane_out & mask;

endmodule

// ----- src/lgs_outq.sv -----
// Three-entry result queue between the row lanes and the output channel.
// Depends on lgs_pkg for the flag and push types.
module lgs_outq #(
  parameter int MAX_WIDTH = lgs_pkg::MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lgs_pkg::lgs_push_t     push,
  input  logic [MAX_WIDTH-1:0]   row_a,
  input  logic [MAX_WIDTH-1:0]   row_b,
  output logic                   room,
  output logic                   head_valid,
  input  logic                   head_ready,
  output logic [MAX_WIDTH-1:0]   head_row,
  output lgs_pkg::lgs_flags_t    head_flags
);
  import lgs_pkg::*;

  localparam int DEPTH = 3;

  logic [MAX_WIDTH-1:0] cells_r   [DEPTH];
  logic [MAX_WIDTH-1:0] cells_nxt [DEPTH];
  lgs_flags_t           flags_r   [DEPTH];
  lgs_flags_t           flags_nxt [DEPTH];
  logic [1:0]           count_r;
  logic [1:0]           count_nxt;
  logic [1:0]           base;
  logic [1:0]           base_b;
  logic                 pop;
  lgs_flags_t           flags_b;

  assign pop        = (count_r != 2'd0) && head_ready;
  assign base       = count_r - 2'(pop);
  assign base_b     = base + 2'd1;
  assign flags_b    = '{grid_done: 1'b1, run_end: 1'b1};
  assign room       = !count_r[1];
  assign head_valid = (count_r != 2'd0);
  assign head_row   = cells_r[0];
  assign head_flags = flags_r[0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && (i < DEPTH - 1)) begin
        cells_nxt[i] = cells_r[(i + 1) % DEPTH];
        flags_nxt[i] = flags_r[(i + 1) % DEPTH];
      end else begin
        cells_nxt[i] = cells_r[i];
        flags_nxt[i] = flags_r[i];
      end
      if (push.push_a && (base == 2'(i))) begin
        cells_nxt[i] = row_a;
        flags_nxt[i] = push.flags_a;
      end
      if (push.push_b && (base_b == 2'(i))) begin
        cells_nxt[i] = row_b;
        flags_nxt[i] = flags_b;
      end
    end
    count_nxt = base + 2'(push.push_a) + 2'(push.push_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_r[i] <= cells_nxt[i];
      flags_r[i] <= flags_nxt[i];
    end
  end

endmodule

// ----- src/life_generation_step.sv -----
// Top level of the Life generation step block: row window, lanes, result queue.
// Depends on lgs_pkg, lgs_row (with lgs_lane) and lgs_outq.
//
// This block computes one generation of Conway's Life (birth on three live
// neighbors, survival on two or three) over a grid streamed in one row per
// transfer, with in_tlast marking the bottom row. Cells beyond the grid edges
// count as dead. The block holds the two most recent rows, and each row
// transfer releases the next generation of the row before it, so results lag
// the input by one row. The first row of a grid releases nothing; the bottom
// row releases two results, the row above it and then itself, the second
// flagged with out_tlast. A grid of a single row gives one result. out_tuser
// is high on the last result that an input transfer causes. grid_width,
// written on the cfg channel while the block is idle, sets how many cells are
// in use; values above MAX_WIDTH saturate, and cells at or above the width
// read as dead and come out as zero. All cells of
// the row are evaluated by parallel lanes in the accepting cycle, and the
// results land in a three-entry output queue, so a row can be taken every
// cycle while the output keeps up. The bottom row puts two results in the
// queue, and the input stalls whenever two results wait.
module life_generation_step #(
  parameter int MAX_WIDTH = lgs_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration channel.
  input  logic                          cfg_tvalid,
  output logic                          cfg_tready,
  input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_tdata,  // [6:0] grid_width, [7] zero
  // Input rows.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lgs_pkg::CELLS_W-1:0]   in_tdata,   // [63:0] row_cells
  input  logic                          in_tlast,   // final_row
  // Result rows.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lgs_pkg::CELLS_W-1:0]   out_tdata,  // [63:0] next_cells
  output logic                          out_tlast,  // grid_done
  output logic                          out_tuser   // run_end
);
  import lgs_pkg::*;

  logic                 in_xfer;
  logic                 cfg_xfer;
  logic [MAX_WIDTH-1:0] mask_r;
  logic [MAX_WIDTH-1:0] mask_nxt;
  logic [MAX_WIDTH-1:0] upper_r;
  logic [MAX_WIDTH-1:0] upper_nxt;
  logic [MAX_WIDTH-1:0] middle_r;
  logic [MAX_WIDTH-1:0] middle_nxt;
  logic                 middle_valid_r;
  logic                 middle_valid_nxt;
  logic [MAX_WIDTH-1:0] row_in;
  logic [MAX_WIDTH-1:0] a_above;
  logic [MAX_WIDTH-1:0] a_here;
  logic [MAX_WIDTH-1:0] a_below;
  logic [MAX_WIDTH-1:0] row_a;
  logic [MAX_WIDTH-1:0] row_b;
  logic [MAX_WIDTH-1:0] head_row;
  lgs_flags_t           head_flags;
  lgs_push_t            push;
  logic                 room;

  // The configuration register is always ready.
  assign cfg_tready = 1'b1;
  assign cfg_xfer   = cfg_tvalid && cfg_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign in_tready  = room;

  // The width is kept as a cell mask. A width at or above MAX_WIDTH sets
  // every bit, which gives the saturation for free.
  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_mask
    assign mask_nxt[k] = (cfg_tdata[GRID_W_W-1:0] > GRID_W_W'(k));
  end

  assign row_in = in_tdata[MAX_WIDTH-1:0] & mask_r;

  // Result A is the row before the incoming one, or the incoming row alone
  // when it is a one-row grid. Result B is the bottom row itself.
  always_comb begin
    if (middle_valid_r) begin
      a_above = upper_r;
      a_here  = middle_r;
      a_below = row_in;
    end else begin
      a_above = '0;
      a_here  = row_in;
      a_below = '0;
    end
  end

  lgs_row #(.MAX_WIDTH(MAX_WIDTH)) u_row_a (
    .mask     (mask_r),
    .above    (a_above),
    .here     (a_here),
    .below    (a_below),
    .next_row (row_a)
  );

  lgs_row #(.MAX_WIDTH(MAX_WIDTH)) u_row_b (
    .mask     (mask_r),
    .above    (middle_r),
    .here     (row_in),
    .below    ('0),
    .next_row (row_b)
  );

  // Row window update and the results each transfer pushes.
  always_comb begin
    upper_nxt         = upper_r;
    middle_nxt        = middle_r;
    middle_valid_nxt  = middle_valid_r;
    push.push_a       = 1'b0;
    push.push_b       = 1'b0;
    push.flags_a      = '{grid_done: !middle_valid_r,
                          run_end: !(middle_valid_r && in_tlast)};
    if (in_xfer) begin
      push.push_a = middle_valid_r || in_tlast;
      push.push_b = middle_valid_r && in_tlast;
      if (in_tlast) begin
        upper_nxt        = '0;
        middle_nxt       = '0;
        middle_valid_nxt = 1'b0;
      end else begin
        upper_nxt        = middle_valid_r ? middle_r : '0;
        middle_nxt       = row_in;
        middle_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r         <= '1;
      middle_valid_r <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        mask_r <= mask_nxt;
      end
      middle_valid_r <= middle_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    upper_r  <= upper_nxt;
    middle_r <= middle_nxt;
  end

  lgs_outq #(.MAX_WIDTH(MAX_WIDTH)) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .row_a      (row_a),
    .row_b      (row_b),
    .room       (room),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head_row   (head_row),
    .head_flags (head_flags)
  );

  assign out_tdata = CELLS_W'(head_row);
  assign out_tlast = head_flags.grid_done;
  assign out_tuser = head_flags.run_end;

`ifndef SYNTHESIS
  // A bottom row always closes the grid, so the next row starts a new one.
  a_grid_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tlast) |=> !middle_valid_r)
    else $error("row window still open after the bottom row");

  // The bottom row of a grid is always the last result of its transfer.
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser)
    else $error("grid_done result without run_end");

  // Cells outside the configured width never come out alive.
  a_masked_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((head_row & ~mask_r) == '0))
    else $error("live cell beyond grid_width");

  // A transfer that opens a grid pushes nothing into the queue.
  a_first_row_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_tlast && !middle_valid_r) |-> (!push.push_a && !push.push_b))
    else $error("result pushed for the first row of a grid");
`endif

endmodule

// ----- tb/sv/life_generation_step_tb.sv -----
// Self-checking testbench for life_generation_step: one Life generation per streamed grid.
// Uses lgs_pkg for port widths and rule counts and needs only the block's RTL.
// Rows are checked against a behavioral row predictor kept inside this file.
`timescale 1ns / 100ps

module life_generation_step_tb;
  import lgs_pkg::*;

  // The instance keeps its default row capacity, so the predictor uses the same figure.
  localparam int ROW_CAP = MAX_WIDTH_DEF;
  localparam int GRID_W_RESET = 64;
  // After the last awaited result, a row with no result of its own may still be
  // settling inside the block, so the width write first waits SETTLE_CYCLES.
  localparam int SETTLE_CYCLES = 6;
  localparam int ROW_TARGET = 1650;
  localparam int MISMATCH_SHOWN = 10;

  // One result row as the block should present it.
  typedef struct {
    logic [CELLS_W-1:0] cells;
    logic               grid_done;
    logic               run_end;
  } life_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_tvalid = 1'b0;
  logic                  cfg_tready;
  logic [CFG_DATA_W-1:0] cfg_tdata = '0;   // [6:0] grid_width, [7] zero

  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [CELLS_W-1:0] in_tdata = '0;       // [63:0] row_cells
  logic               in_tlast = 1'b0;     // final_row

  logic               out_tvalid;
  logic               out_tready;
  logic [CELLS_W-1:0] out_tdata;           // [63:0] next_cells
  logic               out_tlast;           // grid_done
  logic               out_tuser;           // run_end

  // Predictor state: the width in force and the two rows the block is holding.
  logic [GRID_W_W-1:0] grid_width_now = GRID_W_RESET[GRID_W_W-1:0];
  logic [CELLS_W-1:0]  row_above = '0;
  logic [CELLS_W-1:0]  row_held = '0;
  logic                held_valid = 1'b0;

  // Next-generation rows still owed by the block, oldest first.
  life_row_t next_gen_q[$];
  life_row_t got_row;
  life_row_t want_row;

  int fail_count = 0;
  int rows_sent = 0;

  // Idling controls shared between the tests and the two stream sides.
  bit in_stall_en = 1'b1;
  bit out_stall_en = 1'b1;
  int out_gap = 0;
  int hold_off_cycles = 0;

  life_generation_step u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // Cells in use for a given register value. Values above the row capacity saturate.
  function automatic logic [CELLS_W-1:0] cells_in_use(input logic [GRID_W_W-1:0] w);
    int eff;
    eff = (int'(w) > ROW_CAP) ? ROW_CAP : int'(w);
    if (eff >= CELLS_W) begin
      return '1;
    end
    return (64'd1 << eff) - 64'd1;
  endfunction

  // Next generation of the middle row, with cells past either end counting as dead.
  function automatic logic [CELLS_W-1:0] evolve_row(input logic [CELLS_W-1:0] above,
                                                    input logic [CELLS_W-1:0] here,
                                                    input logic [CELLS_W-1:0] below,
                                                    input logic [CELLS_W-1:0] mask);
    logic [CELLS_W-1:0] a;
    logic [CELLS_W-1:0] h;
    logic [CELLS_W-1:0] b;
    logic [CELLS_W-1:0] res;
    int cnt;
    int k;
    a = above & mask;
    h = here & mask;
    b = below & mask;
    res = '0;
    for (k = 0; k < CELLS_W; k++) begin
      cnt = int'(a[k]) + int'(b[k]);
      if (k > 0) begin
        cnt += int'(a[k-1]) + int'(h[k-1]) + int'(b[k-1]);
      end
      if (k < CELLS_W - 1) begin
        cnt += int'(a[k+1]) + int'(h[k+1]) + int'(b[k+1]);
      end
      if (cnt == int'(BIRTH_COUNT) || (h[k] && cnt == int'(SURVIVE_COUNT))) begin
        res[k] = 1'b1;
      end
    end
    return res & mask;
  endfunction

  function automatic void owe_row(input logic [CELLS_W-1:0] cells, input logic done,
                                  input logic run_end);
    life_row_t r;
    r.cells = cells;
    r.grid_done = done;
    r.run_end = run_end;
    next_gen_q.push_back(r);
  endfunction

  // Advance the predictor by one accepted input row and queue what it releases.
  function automatic void predict_next_rows(input logic [CELLS_W-1:0] cells,
                                            input logic last);
    logic [CELLS_W-1:0] mask;
    logic [CELLS_W-1:0] row;
    mask = cells_in_use(grid_width_now);
    row = cells & mask;
    if (!held_valid) begin
      if (last) begin
        // A grid of one row: dead rows above and below.
        owe_row(evolve_row('0, row, '0, mask), 1'b1, 1'b1);
      end else begin
        row_above = '0;
        row_held = row;
        held_valid = 1'b1;
      end
    end else begin
      owe_row(evolve_row(row_above, row_held, row, mask), 1'b0, !last);
      if (last) begin
        owe_row(evolve_row(row_held, row, '0, mask), 1'b1, 1'b1);
        row_above = '0;
        row_held = '0;
        held_valid = 1'b0;
      end else begin
        row_above = row_held;
        row_held = row;
      end
    end
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MISMATCH_SHOWN) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CELLS_W-1:0] random_row();
    logic [CELLS_W-1:0] a;
    logic [CELLS_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return a & b;
      4: return a | b;
      default: return a;
    endcase
  endfunction

  function automatic logic [GRID_W_W-1:0] random_width();
    case ($urandom_range(0, 11))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'($urandom_range(ROW_CAP + 1, 127));
      4: return 7'd64;
      5: return 7'd63;
      default: return 7'($urandom_range(3, ROW_CAP));
    endcase
  endfunction

  // Receiver side. A hold-off asked for by a test takes priority over the
  // ordinary random stalls, and it is counted down here one cycle at a time.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_tready = 1'b0;
        hold_off_cycles--;
      end else if (out_gap > 0) begin
        out_tready = 1'b0;
        out_gap--;
      end else begin
        out_tready = 1'b1;
        out_gap = out_stall_en ? idle_len() : 0;
      end
    end
  end

  // Every result transfer is matched against the oldest owed row.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_row.cells = out_tdata;
      got_row.grid_done = out_tlast;
      got_row.run_end = out_tuser;
      if (next_gen_q.size() == 0) begin
        note_failure($sformatf("unexpected result: cells %h done %b run_end %b",
                               got_row.cells, got_row.grid_done, got_row.run_end));
      end else begin
        want_row = next_gen_q.pop_front();
        if (got_row.cells !== want_row.cells) begin
          note_failure($sformatf("next_cells: expected %h, got %h",
                                 want_row.cells, got_row.cells));
        end
        if (got_row.grid_done !== want_row.grid_done) begin
          note_failure($sformatf("grid_done: expected %b, got %b",
                                 want_row.grid_done, got_row.grid_done));
        end
        if (got_row.run_end !== want_row.run_end) begin
          note_failure($sformatf("run_end: expected %b, got %b",
                                 want_row.run_end, got_row.run_end));
        end
      end
    end
  end

  // Offer one row and wait for its transfer. Entered and left at a falling edge.
  task automatic send_row(input logic [CELLS_W-1:0] cells, input logic last);
    int gap;
    gap = in_stall_en ? idle_len() : 0;
    repeat (gap) @(negedge clk);
    in_tdata = cells;
    in_tlast = last;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_next_rows(cells, last);
    rows_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Wait until every owed row has been seen, then return at a falling edge.
  task automatic wait_drained();
    while (next_gen_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // The width register is only written once the block has gone quiet.
  task automatic set_grid_width(input logic [GRID_W_W-1:0] w);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_tdata = {1'b0, w};
    cfg_tvalid = 1'b1;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    grid_width_now = w;
    @(negedge clk);
    cfg_tvalid = 1'b0;
  endtask

  task automatic send_grid(input int height);
    int r;
    for (r = 0; r < height; r++) begin
      send_row(random_row(), r == height - 1);
    end
  endtask

  // Grids of a single row at the reset width: full, empty and checkerboard rows.
  task automatic test_single_row_grids();
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
  endtask

  // Small known patterns, including live cells on both edges of the row.
  task automatic test_known_patterns();
    // Horizontal blinker turns vertical.
    send_row('0, 1'b0);
    send_row(64'h0000_0000_0001_C000, 1'b0);
    send_row('0, 1'b1);
    // Edge columns on three rows.
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b1);
    // Two full rows: only the corners survive.
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    // Glider.
    send_row(64'h0000_0000_0000_0004, 1'b0);
    send_row(64'h0000_0000_0000_0008, 1'b0);
    send_row(64'h0000_0000_0000_000E, 1'b1);
  endtask

  // Saturating, zero, one-cell and near-full widths.
  task automatic test_width_extremes();
    set_grid_width(7'd127);
    send_row(random_row(), 1'b0);
    send_row('1, 1'b1);
    set_grid_width(7'd0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    set_grid_width(7'd1);
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    set_grid_width(7'd3);
    send_row('1, 1'b1);
    set_grid_width(7'd63);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
  endtask

  // The width changes while rows of a grid are held; held rows keep their bits.
  task automatic test_width_mid_grid();
    set_grid_width(7'd64);
    send_row('1, 1'b0);
    set_grid_width(7'd9);
    send_row('1, 1'b0);
    send_row(random_row(), 1'b0);
    set_grid_width(7'd40);
    send_row('1, 1'b1);
    set_grid_width(7'd64);
  endtask

  // The receiver holds off long enough for the block to stall its input, then
  // the sender waits for the backlog to clear before going on.
  task automatic test_backpressure();
    int n;
    in_stall_en = 1'b0;
    hold_off_cycles = 200;
    for (n = 0; n < 24; n++) begin
      send_row(random_row(), (n % 6) == 5);
    end
    wait_drained();
    send_grid(5);
    in_stall_en = 1'b1;
  endtask

  // Well-formed grids of random height and content, with the width changed now
  // and then between grids and sometimes inside one.
  task automatic test_random_grids();
    int height;
    int split_at;
    int r;
    while (rows_sent < ROW_TARGET) begin
      // Each side runs with no idling in roughly one grid in five, chosen apart.
      in_stall_en = ($urandom_range(0, 4) != 0);
      out_stall_en = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 5) == 0) begin
        set_grid_width(random_width());
      end
      height = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
      split_at = ($urandom_range(0, 9) == 0 && height > 1) ? $urandom_range(1, height - 1) : -1;
      for (r = 0; r < height; r++) begin
        if (r == split_at) begin
          set_grid_width(random_width());
        end
        send_row(random_row(), r == height - 1);
      end
    end
    in_stall_en = 1'b1;
    out_stall_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_single_row_grids();
    test_known_patterns();
    test_width_extremes();
    test_width_mid_grid();
    test_backpressure();
    test_random_grids();

    wait_drained();
    repeat (20) @(negedge clk);
    if (next_gen_q.size() != 0) begin
      note_failure($sformatf("%0d result rows never arrived", next_gen_q.size()));
    end
    if (fail_count == 0) begin
      $display("life_generation_step regression: pass");
    end else begin
      $display("life_generation_step regression: fail");
    end
    $finish;
  end

  // Far beyond the slowest correct run, including every long stall.
  initial begin
    #15_000_000;
    $display("life_generation_step regression: fail");
    $finish;
  end

endmodule
